// ----- hw/rtl/hpackd_pkg.sv -----
// Shared types, code-length groups and symbol table for the HPACK Huffman decoder.
package hpackd_pkg;

   localparam int MAX_CODE_BITS = 30;
   localparam int ACC_BITS      = 37;
   localparam int NUM_GROUPS    = 21;

   typedef struct packed {
      logic [7:0] coded_byte;
      logic       string_end;
   } req_item_type;

   typedef struct packed {
      logic [7:0] symbol;
      logic       last_of_run;
      logic       string_done;
   } rsp_item_type;

   typedef struct packed {
      logic [4:0]  len;
      logic [29:0] first;
      logic [5:0]  count;
      logic [8:0]  base;
   } group_type;

   typedef enum logic {
      ST_LOAD,
      ST_DECODE
   } dec_state_type;

   localparam logic [8:0] EOS_INDEX = 9'd256;

   // Canonical code groups: length, first code, code count, first symbol index.
   function automatic group_type group_info(input logic [4:0] g);
      group_type r;
      case (g)
         5'd0:  r = '{5'd5,  30'h0,        6'd10, 9'd0};
         5'd1:  r = '{5'd6,  30'h14,       6'd26, 9'd10};
         5'd2:  r = '{5'd7,  30'h5c,       6'd32, 9'd36};
         5'd3:  r = '{5'd8,  30'hf8,       6'd6,  9'd68};
         5'd4:  r = '{5'd10, 30'h3f8,      6'd5,  9'd74};
         5'd5:  r = '{5'd11, 30'h7fa,      6'd3,  9'd79};
         5'd6:  r = '{5'd12, 30'hffa,      6'd2,  9'd82};
         5'd7:  r = '{5'd13, 30'h1ff8,     6'd6,  9'd84};
         5'd8:  r = '{5'd14, 30'h3ffc,     6'd2,  9'd90};
         5'd9:  r = '{5'd15, 30'h7ffc,     6'd3,  9'd92};
         5'd10: r = '{5'd19, 30'h7fff0,    6'd3,  9'd95};
         5'd11: r = '{5'd20, 30'hfffe6,    6'd8,  9'd98};
         5'd12: r = '{5'd21, 30'h1fffdc,   6'd13, 9'd106};
         5'd13: r = '{5'd22, 30'h3fffd2,   6'd26, 9'd119};
         5'd14: r = '{5'd23, 30'h7fffd8,   6'd29, 9'd145};
         5'd15: r = '{5'd24, 30'hffffea,   6'd12, 9'd174};
         5'd16: r = '{5'd25, 30'h1ffffec,  6'd4,  9'd186};
         5'd17: r = '{5'd26, 30'h3ffffe0,  6'd15, 9'd190};
         5'd18: r = '{5'd27, 30'h7ffffde,  6'd19, 9'd205};
         5'd19: r = '{5'd28, 30'hfffffe2,  6'd29, 9'd224};
         5'd20: r = '{5'd30, 30'h3ffffffc, 6'd4,  9'd253};
         default: r = '{5'd30, 30'h3ffffffc, 6'd4, 9'd253};
      endcase
      return r;
   endfunction

   // Upper bound (exclusive) of a group in the left-aligned 30-bit window.
   function automatic logic [30:0] group_end(input logic [4:0] g);
      group_type  r;
      logic [30:0] top;
      r   = group_info(g);
      top = {1'b0, r.first} + 31'(r.count);
      return top << (5'(MAX_CODE_BITS) - r.len);
   endfunction

   // Symbols in code order.
   localparam logic [7:0] SYM_TABLE [0:255] = '{
      8'd48, 8'd49, 8'd50, 8'd97, 8'd99, 8'd101, 8'd105, 8'd111, 8'd115, 8'd116,
      8'd32, 8'd37, 8'd45, 8'd46, 8'd47, 8'd51, 8'd52, 8'd53, 8'd54, 8'd55,
      8'd56, 8'd57, 8'd61, 8'd65, 8'd95, 8'd98, 8'd100, 8'd102, 8'd103, 8'd104,
      8'd108, 8'd109, 8'd110, 8'd112, 8'd114, 8'd117,
      8'd58, 8'd66, 8'd67, 8'd68, 8'd69, 8'd70, 8'd71, 8'd72, 8'd73, 8'd74,
      8'd75, 8'd76, 8'd77, 8'd78, 8'd79, 8'd80, 8'd81, 8'd82, 8'd83, 8'd84,
      8'd85, 8'd86, 8'd87, 8'd89, 8'd106, 8'd107, 8'd113, 8'd118, 8'd119, 8'd120,
      8'd121, 8'd122,
      8'd38, 8'd42, 8'd44, 8'd59, 8'd88, 8'd90,
      8'd33, 8'd34, 8'd40, 8'd41, 8'd63,
      8'd39, 8'd43, 8'd124,
      8'd35, 8'd62,
      8'd0, 8'd36, 8'd64, 8'd91, 8'd93, 8'd126,
      8'd94, 8'd125,
      8'd60, 8'd96, 8'd123,
      8'd92, 8'd195, 8'd208,
      8'd128, 8'd130, 8'd131, 8'd162, 8'd184, 8'd194, 8'd224, 8'd226,
      8'd153, 8'd161, 8'd167, 8'd172, 8'd176, 8'd177, 8'd179, 8'd209, 8'd216,
      8'd217, 8'd227, 8'd229, 8'd230,
      8'd129, 8'd132, 8'd133, 8'd134, 8'd136, 8'd146, 8'd154, 8'd156, 8'd160,
      8'd163, 8'd164, 8'd169, 8'd170, 8'd173, 8'd178, 8'd181, 8'd185, 8'd186,
      8'd187, 8'd189, 8'd190, 8'd196, 8'd198, 8'd228, 8'd232, 8'd233,
      8'd1, 8'd135, 8'd137, 8'd138, 8'd139, 8'd140, 8'd141, 8'd143, 8'd147,
      8'd149, 8'd150, 8'd151, 8'd152, 8'd155, 8'd157, 8'd158, 8'd165, 8'd166,
      8'd168, 8'd174, 8'd175, 8'd180, 8'd182, 8'd183, 8'd188, 8'd191, 8'd197,
      8'd231, 8'd239,
      8'd9, 8'd142, 8'd144, 8'd145, 8'd148, 8'd159, 8'd171, 8'd206, 8'd215,
      8'd225, 8'd236, 8'd237,
      8'd199, 8'd207, 8'd234, 8'd235,
      8'd192, 8'd193, 8'd200, 8'd201, 8'd202, 8'd205, 8'd210, 8'd213, 8'd218,
      8'd219, 8'd238, 8'd240, 8'd242, 8'd243, 8'd255,
      8'd203, 8'd204, 8'd211, 8'd212, 8'd214, 8'd221, 8'd222, 8'd223, 8'd241,
      8'd244, 8'd245, 8'd246, 8'd247, 8'd248, 8'd250, 8'd251, 8'd252, 8'd253,
      8'd254,
      8'd2, 8'd3, 8'd4, 8'd5, 8'd6, 8'd7, 8'd8, 8'd11, 8'd12, 8'd14, 8'd15,
      8'd16, 8'd17, 8'd18, 8'd19, 8'd20, 8'd21, 8'd23, 8'd24, 8'd25, 8'd26,
      8'd27, 8'd28, 8'd29, 8'd30, 8'd31,
      8'd127, 8'd220, 8'd249,
      8'd10, 8'd13, 8'd22
   };

endpackage

// ----- hw/rtl/hpackd_queue.sv -----
// Small first-in first-out word queue used on both sides of the decoder.
module hpackd_queue #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             full,
   output logic             not_empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full      = (cnt_ff == CNT_W'(DEPTH));
   assign not_empty = (cnt_ff != '0);
   assign do_push   = push && !full;
   assign do_pop    = pop && not_empty;
   assign pop_data  = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end

endmodule

// ----- hw/rtl/hpackd_decode.sv -----
// Back part: bit accumulator, one Huffman code per cycle unless stalled, symbol emission.
module hpackd_decode
   import hpackd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic [15:0]  output_limit,
   input  logic         in_valid,
   input  req_item_type in_item,
   output logic         in_pop,
   input  logic         out_full,
   output logic         out_push,
   output rsp_item_type out_item
);

   dec_state_type st_ff, st_in;
   logic [ACC_BITS-1:0] acc_ff, acc_in;
   logic [5:0]          held_ff, held_in;
   logic [15:0]         emitted_ff, emitted_in;
   logic [1:0]          n_ff, n_in;
   logic                last_ff, last_in;
   logic                pend_vld_ff, pend_vld_in;
   rsp_item_type        pend_ff, pend_in;

   logic [66:0]         wide;
   logic [29:0]         win;
   logic [4:0]          sel;
   group_type           info;
   logic [29:0]         code;
   logic [8:0]          off;
   logic [8:0]          idx;
   logic                found;
   logic                emit;
   logic [16:0]         emitted_inc;
   logic [ACC_BITS-1:0] acc_post;
   logic [5:0]          held_post;
   logic [15:0]         emitted_post;
   logic [5:0]          held_load;

   // Head code of the pending bits, left-aligned into a 30-bit window.
   always_comb begin
      wide = {acc_ff, 30'b0} >> held_ff;
      win  = wide[29:0];
      sel  = 5'(NUM_GROUPS - 1);
      for (int g = NUM_GROUPS - 1; g >= 0; g--) begin
         if ({1'b0, win} < group_end(5'(g))) begin
            sel = 5'(g);
         end
      end
      info  = group_info(sel);
      code  = win >> (5'(MAX_CODE_BITS) - info.len);
      off   = 9'(code - info.first);
      idx   = info.base + off;
      found = (held_ff >= {1'b0, info.len});
   end

   assign emitted_inc = {1'b0, emitted_ff} + 17'd1;
   assign emit = (idx != EOS_INDEX) && (emitted_ff < output_limit) && (n_ff != 2'd2);

   always_comb begin
      st_in       = st_ff;
      acc_in      = acc_ff;
      held_in     = held_ff;
      emitted_in  = emitted_ff;
      n_in        = n_ff;
      last_in     = last_ff;
      pend_vld_in = pend_vld_ff;
      pend_in     = pend_ff;
      in_pop      = 1'b0;
      out_push    = 1'b0;
      out_item    = pend_ff;
      acc_post    = acc_ff;
      held_post   = held_ff;
      emitted_post = emitted_ff;
      held_load   = 6'd0;
      case (st_ff)
         ST_LOAD: begin
            if (in_valid) begin
               in_pop    = 1'b1;
               acc_in    = {acc_ff[ACC_BITS-9:0], in_item.coded_byte};
               held_load = held_ff + 6'd8;
               held_in   = (held_load > 6'(ACC_BITS)) ? 6'(ACC_BITS) : held_load;
               last_in   = in_item.string_end;
               n_in      = 2'd0;
               st_in     = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (found) begin
               // Consume one code; hold if a waiting symbol cannot leave yet.
               if (!(emit && pend_vld_ff && out_full)) begin
                  held_in = held_ff - {1'b0, info.len};
                  acc_in  = acc_ff & ((ACC_BITS'(1) << held_in) - ACC_BITS'(1));
                  if (emit) begin
                     out_push    = pend_vld_ff;
                     out_item    = pend_ff;
                     out_item.last_of_run = 1'b0;
                     pend_vld_in = 1'b1;
                     pend_in.symbol      = SYM_TABLE[idx[7:0]];
                     pend_in.last_of_run = 1'b1;
                     pend_in.string_done = (emitted_inc >= {1'b0, output_limit});
                     emitted_in  = emitted_inc[15:0];
                     n_in        = n_ff + 2'd1;
                  end
               end
            end else if (!(pend_vld_ff && out_full)) begin
               // End of this word: release the waiting symbol as last of run.
               out_push    = pend_vld_ff;
               out_item    = pend_ff;
               out_item.last_of_run = 1'b1;
               out_item.string_done = pend_ff.string_done | last_ff;
               pend_vld_in = 1'b0;
               if (last_ff) begin
                  acc_post     = '0;
                  held_post    = 6'd0;
                  emitted_post = 16'd0;
               end
               acc_in     = acc_post;
               held_in    = held_post;
               emitted_in = emitted_post;
               st_in      = ST_LOAD;
               // Start the next word right away when one is queued.
               if (in_valid) begin
                  in_pop    = 1'b1;
                  acc_in    = {acc_post[ACC_BITS-9:0], in_item.coded_byte};
                  held_load = held_post + 6'd8;
                  held_in   = (held_load > 6'(ACC_BITS)) ? 6'(ACC_BITS) : held_load;
                  last_in   = in_item.string_end;
                  n_in      = 2'd0;
                  st_in     = ST_DECODE;
               end
            end
         end
         default: begin
            st_in = ST_LOAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff       <= ST_LOAD;
         acc_ff      <= '0;
         held_ff     <= '0;
         emitted_ff  <= '0;
         n_ff        <= '0;
         last_ff     <= 1'b0;
         pend_vld_ff <= 1'b0;
      end else begin
         st_ff       <= st_in;
         acc_ff      <= acc_in;
         held_ff     <= held_in;
         emitted_ff  <= emitted_in;
         n_ff        <= n_in;
         last_ff     <= last_in;
         pend_vld_ff <= pend_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

// ----- hw/rtl/hpack_huffman_decoder.sv -----
// Top level of the HPACK static Huffman decoder.
//
//   channel | direction | tdata            | tlast        | tuser
//   req_    | in        | [7:0] coded_byte | string_end   | -
//   rsp_    | out       | [7:0] symbol     | last_of_run  | string_done
//   csr_    | in        | [15:0] output_limit (write only, always ready)
//
// A coded word is loaded into the accumulator, then its completed codes are decoded
// one per cycle while the result side does not stall, then a closing step releases
// the waiting symbol and overlaps the load of the next word.
// Reset clears the bit accumulator, the counters and both queues; the limit
// returns to 65535. A stalled result side fills the result queue, then holds
// the decoder, then the input queue; input words keep entering until it fills.
module hpack_huffman_decoder
   import hpackd_pkg::*;
#(
   parameter int IN_DEPTH  = 2,
   parameter int OUT_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] coded_byte
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] symbol
   output logic        rsp_tlast,
   output logic [0:0]  rsp_tuser,   // [0] string_done
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   logic [15:0]  limit_ff;
   req_item_type req_item, dec_item;
   rsp_item_type dec_out, rsp_item;
   logic         in_full, in_nempty, in_pop;
   logic         out_full, out_push;

   // Limit register: the user must write it only while idle; the block does not enforce this.
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= 16'hFFFF;
      end else if (csr_valid) begin
         limit_ff <= csr_data;
      end
   end

   // Front: queue incoming words.
   assign req_item.coded_byte = req_tdata;
   assign req_item.string_end = req_tlast;
   assign req_tready = !in_full;

   hpackd_queue #(
      .WIDTH ($bits(req_item_type)),
      .DEPTH (IN_DEPTH)
   ) u_in_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_tvalid),
      .push_data (req_item),
      .pop       (in_pop),
      .pop_data  (dec_item),
      .full      (in_full),
      .not_empty (in_nempty)
   );

   // Back: decode codes from the accumulator.
   hpackd_decode u_decode (
      .clock        (clock),
      .reset        (reset),
      .output_limit (limit_ff),
      .in_valid     (in_nempty),
      .in_item      (dec_item),
      .in_pop       (in_pop),
      .out_full     (out_full),
      .out_push     (out_push),
      .out_item     (dec_out)
   );

   // Result queue toward the consumer.
   hpackd_queue #(
      .WIDTH ($bits(rsp_item_type)),
      .DEPTH (OUT_DEPTH)
   ) u_out_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (dec_out),
      .pop       (rsp_tready),
      .pop_data  (rsp_item),
      .full      (out_full),
      .not_empty (rsp_tvalid)
   );

   assign rsp_tdata = rsp_item.symbol;
   assign rsp_tlast = rsp_item.last_of_run;
   assign rsp_tuser = rsp_item.string_done;

endmodule

// ----- hw/rtl/hpackd_checker.sv -----
// Port-level checks for the HPACK Huffman decoder, bound to the top level.
module hpackd_checker (
   input logic       clock,
   input logic       reset,
   input logic       rsp_tvalid,
   input logic       rsp_tready,
   input logic [7:0] rsp_tdata,
   input logic       rsp_tlast,
   input logic [0:0] rsp_tuser,
   input logic       csr_ready
);

   // A waiting result holds its word.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result word changed while stalled");

   // Nothing is offered right after reset.
   a_rsp_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // A string-done flag always closes the run of its word.
   a_done_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser[0] |-> rsp_tlast)
      else $error("string done without last of run");

   // The limit register never pushes back.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset) csr_ready)
      else $error("configuration port not ready");

endmodule

bind hpack_huffman_decoder hpackd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast),
   .rsp_tuser  (rsp_tuser),
   .csr_ready  (csr_ready)
);
